// ----- hdl/ase_pkg.sv -----
package ase_pkg;

  // Field widths of the item and configuration channels
  localparam int COORD_W      = 31;
  localparam int STEP_W       = 30;
  localparam int KIND_W       = 4;
  localparam int LAYER_PORT_W = 64;
  localparam int SLOT_W       = 6;
  localparam int MODE_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // Default sizes of the anchor table
  localparam int ANCHOR_DEPTH_DEF = 64;
  localparam int LAYER_BITS_DEF   = 64;

  // Grid divider: numerator 2*|d| + step, denominator 2*step
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 31;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Register reset values
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(100000);
  localparam logic [COORD_W-1:0] OFF_RESET  = '0;
  localparam logic [MODE_W-1:0]  MODE_RESET = MODE_W'(3);

  // Mode bit positions
  localparam int MODE_GRID = 0;
  localparam int MODE_SNAP = 1;
  localparam int MODE_AUX  = 2;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } ase_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X = 3'd0,
    REG_STEP_Y = 3'd1,
    REG_OFF_X  = 3'd2,
    REG_OFF_Y  = 3'd3,
    REG_AUX_X  = 3'd4,
    REG_AUX_Y  = 3'd5,
    REG_MODE   = 3'd6
  } ase_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_WAIT,
    ST_GRID,
    ST_PICK,
    ST_EMIT
  } ase_state_t;

  typedef struct packed {
    logic latch_in;
    logic do_write;
    logic do_clear;
    logic load_misc;
    logic query_init;
    logic scan_issue;
    logic grid_calc;
    logic pick;
    logic emit;
  } ase_cmd_t;

  typedef struct packed {
    ase_action_t action;
    logic        empty;
    logic        scan_last;
    logic        pipe_busy;
    logic        div_busy;
    logic        out_free;
  } ase_sts_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- hdl/ase_ram.sv -----
module ase_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [ase_pkg::addr_bits(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [ase_pkg::addr_bits(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ase_div.sv -----
module ase_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ase_pkg::DIV_NUM_W-1:0] num,
  input  logic [ase_pkg::DIV_DEN_W-1:0] den,
  output logic [ase_pkg::DIV_DEN_W-1:0] rem,
  output logic                          busy
);
  import ase_pkg::*;

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W:0]   trial;

  // One restoring step per cycle, MSB first
  always_comb begin
    trial   = {rem_r, num_r[DIV_NUM_W-1]};
    num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
    cnt_nxt = cnt_r - DIV_CNT_W'(1);
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = DIV_DEN_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

// ----- hdl/ase_ctrl.sv -----
module ase_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ase_pkg::ase_sts_t sts,
  output ase_pkg::ase_cmd_t cmd
);
  import ase_pkg::*;

  ase_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (sts.action == ACT_QUERY) begin
          state_nxt = sts.empty ? ST_WAIT : ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (!sts.pipe_busy && !sts.div_busy) state_nxt = ST_GRID;
      end
      ST_GRID: state_nxt = ST_PICK;
      ST_PICK: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_START: begin
        if (sts.action == ACT_QUERY) begin
          cmd.query_init = 1'b1;
        end else begin
          cmd.load_misc = 1'b1;
          cmd.do_write  = (sts.action == ACT_ADD);
          cmd.do_clear  = (sts.action == ACT_CLEAR);
        end
      end
      ST_SCAN: cmd.scan_issue = 1'b1;
      ST_WAIT: ;
      ST_GRID: cmd.grid_calc = 1'b1;
      ST_PICK: cmd.pick = 1'b1;
      ST_EMIT: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hdl/ase_dp.sv -----
module ase_dp #(
  parameter int ANCHOR_DEPTH = ase_pkg::ANCHOR_DEPTH_DEF,
  parameter int LAYER_BITS   = ase_pkg::LAYER_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  ase_pkg::ase_cmd_t                       cmd,
  output ase_pkg::ase_sts_t                       sts,
  input  logic [1:0]                              in_action,
  input  logic signed [ase_pkg::COORD_W-1:0]      in_point_x,
  input  logic signed [ase_pkg::COORD_W-1:0]      in_point_y,
  input  logic [ase_pkg::KIND_W-1:0]              in_kind_flags,
  input  logic [ase_pkg::LAYER_PORT_W-1:0]        in_layer_mask,
  input  logic                                    cfg_valid,
  input  logic [ase_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ase_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ase_pkg::COORD_W-1:0]      out_result_x,
  output logic signed [ase_pkg::COORD_W-1:0]      out_result_y,
  output logic                                    out_hit_anchor,
  output logic [ase_pkg::SLOT_W-1:0]              out_anchor_slot,
  output logic                                    out_status
);
  import ase_pkg::*;

  localparam int ADDR_W  = addr_bits(ANCHOR_DEPTH);
  localparam int CNT_W   = $clog2(ANCHOR_DEPTH + 1);
  localparam int ENTRY_W = 2 * COORD_W + KIND_W + LAYER_BITS;
  localparam int SQ_W    = 2 * STEP_W;
  localparam int D2_W    = 64;
  localparam int G_W     = COORD_W + 3;
  localparam logic signed [G_W-1:0] SAT_MAX = G_W'(1073741823);
  localparam logic signed [G_W-1:0] SAT_MIN = -G_W'(1073741824);

  // Configuration registers
  logic [STEP_W-1:0]         step_x_r, step_y_r;
  logic signed [COORD_W-1:0] off_x_r, off_y_r, aux_x_r, aux_y_r;
  logic [MODE_W-1:0]         mode_r;
  logic [SQ_W-1:0]           thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= STEP_RESET;
      step_y_r <= STEP_RESET;
      off_x_r  <= OFF_RESET;
      off_y_r  <= OFF_RESET;
      aux_x_r  <= OFF_RESET;
      aux_y_r  <= OFF_RESET;
      mode_r   <= MODE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEP_X: step_x_r <= cfg_wdata[STEP_W-1:0];
        REG_STEP_Y: step_y_r <= cfg_wdata[STEP_W-1:0];
        REG_OFF_X:  off_x_r  <= cfg_wdata[COORD_W-1:0];
        REG_OFF_Y:  off_y_r  <= cfg_wdata[COORD_W-1:0];
        REG_AUX_X:  aux_x_r  <= cfg_wdata[COORD_W-1:0];
        REG_AUX_Y:  aux_y_r  <= cfg_wdata[COORD_W-1:0];
        REG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Snap range squared, refreshed every cycle
  always_ff @(posedge clk) begin
    thr_r <= step_x_r * step_x_r;
  end

  // Latch the accepted item
  ase_action_t               act_r;
  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic [KIND_W-1:0]         qflags_r;
  logic [LAYER_BITS-1:0]     qlay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_NONE;
    end else if (cmd.latch_in) begin
      act_r <= ase_action_t'(in_action);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      qx_r     <= in_point_x;
      qy_r     <= in_point_y;
      qflags_r <= in_kind_flags;
      qlay_r   <= in_layer_mask[LAYER_BITS-1:0];
    end
  end

  // Anchor count
  logic [CNT_W-1:0] cnt_r;
  logic             full;
  assign full = (cnt_r == CNT_W'(ANCHOR_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.do_clear) begin
      cnt_r <= '0;
    end else if (cmd.do_write && !full) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Scan address
  logic [ADDR_W-1:0] scan_addr_r;
  logic [CNT_W-1:0]  scan_next;
  assign scan_next = CNT_W'(scan_addr_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_addr_r <= scan_addr_r + ADDR_W'(1);
    end
  end

  // Anchor table
  logic [ENTRY_W-1:0] rdata;

  ase_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ANCHOR_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.do_write && !full),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({qx_r, qy_r, qflags_r, qlay_r}),
    .raddr (scan_addr_r),
    .rdata (rdata)
  );

  // Read stage
  logic              rd_vld_r;
  logic [ADDR_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r;
  end

  logic signed [COORD_W-1:0] ent_x, ent_y;
  logic [KIND_W-1:0]         ent_kind;
  logic [LAYER_BITS-1:0]     ent_lay;
  logic signed [COORD_W:0]   ddx, ddy;
  logic                      match;

  assign {ent_x, ent_y, ent_kind, ent_lay} = rdata;
  assign ddx   = (COORD_W+1)'(ent_x) - (COORD_W+1)'(qx_r);
  assign ddy   = (COORD_W+1)'(ent_y) - (COORD_W+1)'(qy_r);
  assign match = ((ent_lay & qlay_r) != '0) && ((ent_kind & qflags_r) == qflags_r);

  // Filter and distance stage
  logic                      a_vld_r, a_match_r;
  logic [COORD_W:0]          a_dx_r, a_dy_r;
  logic [ADDR_W-1:0]         a_idx_r;
  logic signed [COORD_W-1:0] a_x_r, a_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_match_r <= match;
    a_dx_r    <= ddx[COORD_W] ? -ddx : ddx;
    a_dy_r    <= ddy[COORD_W] ? -ddy : ddy;
    a_idx_r   <= rd_idx_r;
    a_x_r     <= ent_x;
    a_y_r     <= ent_y;
  end

  // Square stage
  logic                      b_vld_r, b_match_r;
  logic [D2_W-1:0]           b_dx2_r, b_dy2_r;
  logic [ADDR_W-1:0]         b_idx_r;
  logic signed [COORD_W-1:0] b_x_r, b_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_match_r <= a_match_r;
    b_dx2_r   <= a_dx_r * a_dx_r;
    b_dy2_r   <= a_dy_r * a_dy_r;
    b_idx_r   <= a_idx_r;
    b_x_r     <= a_x_r;
    b_y_r     <= a_y_r;
  end

  // Sum and keep the first nearest match
  logic                      found_r;
  logic [D2_W-1:0]           best_d2_r;
  logic [ADDR_W-1:0]         best_idx_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;
  logic [D2_W-1:0]           d2;
  logic                      better;

  assign d2     = b_dx2_r + b_dy2_r;
  assign better = b_vld_r && b_match_r && (!found_r || d2 < best_d2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.query_init) begin
      found_r <= 1'b0;
    end else if (better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_d2_r  <= d2;
      best_idx_r <= b_idx_r;
      best_x_r   <= b_x_r;
      best_y_r   <= b_y_r;
    end
  end

  // Grid dividers, run alongside the scan
  logic [STEP_W-1:0]       sx, sy;
  logic signed [COORD_W:0] gdx, gdy;
  logic [COORD_W:0]        gax, gay;
  logic [DIV_NUM_W-1:0]    numx_r, numy_r;
  logic                    negx_r, negy_r;
  logic [DIV_DEN_W-1:0]    remx, remy;
  logic                    busyx, busyy;

  assign sx  = (step_x_r == '0) ? STEP_W'(1) : step_x_r;
  assign sy  = (step_y_r == '0) ? STEP_W'(1) : step_y_r;
  assign gdx = (COORD_W+1)'(qx_r) - (COORD_W+1)'(off_x_r);
  assign gdy = (COORD_W+1)'(qy_r) - (COORD_W+1)'(off_y_r);
  assign gax = gdx[COORD_W] ? -gdx : gdx;
  assign gay = gdy[COORD_W] ? -gdy : gdy;

  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      numx_r <= DIV_NUM_W'({gax, 1'b0}) + DIV_NUM_W'(sx);
      numy_r <= DIV_NUM_W'({gay, 1'b0}) + DIV_NUM_W'(sy);
      negx_r <= gdx[COORD_W];
      negy_r <= gdy[COORD_W];
    end
  end

  ase_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.query_init),
    .num   (DIV_NUM_W'({gax, 1'b0}) + DIV_NUM_W'(sx)),
    .den   ({sx, 1'b0}),
    .rem   (remx),
    .busy  (busyx)
  );

  ase_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.query_init),
    .num   (DIV_NUM_W'({gay, 1'b0}) + DIV_NUM_W'(sy)),
    .den   ({sy, 1'b0}),
    .rem   (remy),
    .busy  (busyy)
  );

  // Grid point: q*step = (num - rem) / 2, signed and shifted back by the origin
  logic [DIV_NUM_W-1:0]  magx_full, magy_full;
  logic signed [G_W-1:0] magx, magy;
  logic signed [G_W-1:0] gx_r, gy_r;

  assign magx_full = numx_r - DIV_NUM_W'(remx);
  assign magy_full = numy_r - DIV_NUM_W'(remy);
  assign magx      = G_W'(magx_full[DIV_NUM_W-1:1]);
  assign magy      = G_W'(magy_full[DIV_NUM_W-1:1]);

  always_ff @(posedge clk) begin
    if (cmd.grid_calc) begin
      gx_r <= (negx_r ? -magx : magx) + G_W'(off_x_r);
      gy_r <= (negy_r ? -magy : magy) + G_W'(off_y_r);
    end
  end

  // Choose anchor, grid, auxiliary axis or raw point
  logic signed [G_W:0]   gex, gey, aex, aey;
  logic [G_W:0]          gmx, gmy, amx, amy;
  logic signed [G_W-1:0] selx, sely, satx, saty;
  logic                  hit;

  assign gex = (G_W+1)'(gx_r) - (G_W+1)'(qx_r);
  assign gey = (G_W+1)'(gy_r) - (G_W+1)'(qy_r);
  assign aex = (G_W+1)'(aux_x_r) - (G_W+1)'(qx_r);
  assign aey = (G_W+1)'(aux_y_r) - (G_W+1)'(qy_r);
  assign gmx = gex[G_W] ? -gex : gex;
  assign gmy = gey[G_W] ? -gey : gey;
  assign amx = aex[G_W] ? -aex : aex;
  assign amy = aey[G_W] ? -aey : aey;
  assign hit = found_r && mode_r[MODE_SNAP] && (best_d2_r <= D2_W'(thr_r));

  always_comb begin
    priority if (hit) begin
      selx = G_W'(best_x_r);
      sely = G_W'(best_y_r);
    end else if (mode_r[MODE_GRID]) begin
      selx = gx_r;
      sely = gy_r;
      if (mode_r[MODE_AUX] && amx < gmx) selx = G_W'(aux_x_r);
      if (mode_r[MODE_AUX] && amy < gmy) sely = G_W'(aux_y_r);
    end else begin
      selx = G_W'(qx_r);
      sely = G_W'(qy_r);
    end
    satx = (selx > SAT_MAX) ? SAT_MAX : ((selx < SAT_MIN) ? SAT_MIN : selx);
    saty = (sely > SAT_MAX) ? SAT_MAX : ((sely < SAT_MIN) ? SAT_MIN : sely);
  end

  // Result registers
  logic signed [COORD_W-1:0]  res_x_r, res_y_r;
  logic                       res_hit_r, res_status_r;
  logic [SLOT_W-1:0]          res_slot_r;
  logic [SLOT_W+ADDR_W-1:0]   best_ext, wr_ext;

  assign best_ext = {{SLOT_W{1'b0}}, best_idx_r};
  assign wr_ext   = {{SLOT_W{1'b0}}, cnt_r[ADDR_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load_misc) begin
      res_x_r      <= '0;
      res_y_r      <= '0;
      res_hit_r    <= 1'b0;
      res_status_r <= (act_r == ACT_ADD) && full;
      res_slot_r   <= ((act_r == ACT_ADD) && !full) ? wr_ext[SLOT_W-1:0] : '0;
    end else if (cmd.pick) begin
      res_x_r      <= satx[COORD_W-1:0];
      res_y_r      <= saty[COORD_W-1:0];
      res_hit_r    <= hit;
      res_status_r <= 1'b0;
      res_slot_r   <= hit ? best_ext[SLOT_W-1:0] : '0;
    end
  end

  // Output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result_x    <= res_x_r;
      out_result_y    <= res_y_r;
      out_hit_anchor  <= res_hit_r;
      out_anchor_slot <= res_slot_r;
      out_status      <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller
  assign sts.action    = act_r;
  assign sts.empty     = (cnt_r == '0);
  assign sts.scan_last = (scan_next == cnt_r);
  assign sts.pipe_busy = rd_vld_r || a_vld_r || b_vld_r;
  assign sts.div_busy  = busyx || busyy;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// ----- hdl/anchor_snap_engine.sv -----
// Anchor snap engine: keeps a table of up to ANCHOR_DEPTH anchor points and
// snaps query points to the nearest matching anchor or to the grid. Clear,
// add and unused actions go from acceptance through the start and emit states
// to the output register. A query reads the table through one RAM port, one
// entry per cycle, into a three-stage distance pipeline while two bit-serial
// dividers round the point to the grid. The configuration port is always
// ready and may be written only while no item is in progress; a result
// waiting in the output register does not hold off the next item.
module anchor_snap_engine #(
  parameter int ANCHOR_DEPTH = ase_pkg::ANCHOR_DEPTH_DEF,
  parameter int LAYER_BITS   = ase_pkg::LAYER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_action,
  input  logic signed [ase_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [ase_pkg::COORD_W-1:0]   in_point_y,
  input  logic [ase_pkg::KIND_W-1:0]           in_kind_flags,
  input  logic [ase_pkg::LAYER_PORT_W-1:0]     in_layer_mask,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ase_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ase_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ase_pkg::COORD_W-1:0]   out_result_x,
  output logic signed [ase_pkg::COORD_W-1:0]   out_result_y,
  output logic                                 out_hit_anchor,
  output logic [ase_pkg::SLOT_W-1:0]           out_anchor_slot,
  output logic                                 out_status
);
  import ase_pkg::*;

  ase_cmd_t cmd;
  ase_sts_t sts;

  assign cfg_ready = 1'b1;

  ase_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ase_dp #(
    .ANCHOR_DEPTH (ANCHOR_DEPTH),
    .LAYER_BITS   (LAYER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_kind_flags   (in_kind_flags),
    .in_layer_mask   (in_layer_mask),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_x    (out_result_x),
    .out_result_y    (out_result_y),
    .out_hit_anchor  (out_hit_anchor),
    .out_anchor_slot (out_anchor_slot),
    .out_status      (out_status)
  );

endmodule

// ----- tb/sv/anchor_snap_engine_tb.sv -----
`timescale 1ns / 100ps

module anchor_snap_engine_tb;
  import ase_pkg::*;

  localparam int DEPTH = 64;
  localparam longint C_MIN = -1073741824;
  localparam longint C_MAX = 1073741823;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 870;

  typedef struct {
    logic [1:0] act;
    longint px;
    longint py;
    logic [3:0] kind;
    logic [63:0] layers;
    bit fixed;
    longint ex;
    longint ey;
    bit ehit;
    int eslot;
    bit estat;
  } item_t;

  typedef struct {
    longint rx;
    longint ry;
    bit hit;
    int slot;
    bit stat;
  } snap_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic [KIND_W-1:0] in_kind_flags = '0;
  logic [LAYER_PORT_W-1:0] in_layer_mask = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_result_x;
  logic signed [COORD_W-1:0] out_result_y;
  logic out_hit_anchor;
  logic [SLOT_W-1:0] out_anchor_slot;
  logic out_status;

  anchor_snap_engine dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow anchor table and registers
  longint tab_x [DEPTH];
  longint tab_y [DEPTH];
  logic [3:0] tab_kind [DEPTH];
  logic [63:0] tab_layers [DEPTH];
  int tab_count = 0;
  longint step_x = 100000, step_y = 100000;
  longint off_x = 0, off_y = 0, aux_x = 0, aux_y = 0;
  logic [2:0] mode = 3'd3;

  snap_t pending_snaps[$];
  item_t directed[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;

  function automatic void add_row(item_t it);
    directed.insert(directed.size(), it);
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp31(longint v);
    if (v < C_MIN) return C_MIN;
    if (v > C_MAX) return C_MAX;
    return v;
  endfunction

  function automatic longint round_to_grid(longint p, longint off, longint step);
    longint s, d, q, g;
    s = (step == 0) ? 1 : step;
    d = p - off;
    q = (2 * iabs(d) + s) / (2 * s);
    g = q * s;
    return (d < 0 ? -g : g) + off;
  endfunction

  // work out the result of one item and update the shadow table
  function automatic snap_t snap_item(item_t it);
    snap_t r;
    bit found;
    int best;
    longint unsigned bd, dx, dy, d2;
    r = '{0, 0, 0, 0, 0};
    found = 0;
    best = 0;
    bd = 0;
    case (it.act)
      ACT_CLEAR: tab_count = 0;
      ACT_ADD: begin
        if (tab_count < DEPTH) begin
          tab_x[tab_count] = it.px;
          tab_y[tab_count] = it.py;
          tab_kind[tab_count] = it.kind;
          tab_layers[tab_count] = it.layers;
          r.slot = tab_count;
          tab_count++;
        end else begin
          r.stat = 1;
        end
      end
      ACT_QUERY: begin
        for (int i = 0; i < tab_count; i++) begin
          if ((tab_layers[i] & it.layers) == 0) continue;
          if ((tab_kind[i] & it.kind) != it.kind) continue;
          dx = iabs(tab_x[i] - it.px);
          dy = iabs(tab_y[i] - it.py);
          d2 = dx * dx + dy * dy;
          if (!found || d2 < bd) begin
            found = 1;
            best = i;
            bd = d2;
          end
        end
        if (found && mode[MODE_SNAP] && bd <= longint'(step_x) * step_x) begin
          r.rx = tab_x[best];
          r.ry = tab_y[best];
          r.hit = 1;
          r.slot = best;
        end else if (mode[MODE_GRID]) begin
          r.rx = round_to_grid(it.px, off_x, step_x);
          r.ry = round_to_grid(it.py, off_y, step_y);
          if (mode[MODE_AUX]) begin
            if (iabs(aux_x - it.px) < iabs(r.rx - it.px)) r.rx = aux_x;
            if (iabs(aux_y - it.py) < iabs(r.ry - it.py)) r.ry = aux_y;
          end
        end else begin
          r.rx = it.px;
          r.ry = it.py;
        end
        r.rx = clamp31(r.rx);
        r.ry = clamp31(r.ry);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk(logic [1:0] a, longint x, longint y, logic [3:0] k,
                               logic [63:0] l);
    item_t it;
    it = '{a, x, y, k, l, 0, 0, 0, 0, 0, 0};
    return it;
  endfunction

  function automatic item_t mk_fixed(item_t it, longint ex, longint ey, bit h,
                                     int s, bit st);
    it.fixed = 1;
    it.ex = ex;
    it.ey = ey;
    it.ehit = h;
    it.eslot = s;
    it.estat = st;
    return it;
  endfunction

  function automatic longint rnd_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return longint'($urandom_range(0, 400000)) - 200000;
      3: return longint'($urandom_range(0, 4000)) - 2000;
      default: return longint'($urandom_range(0, 32'h7FFFFFFF)) + C_MIN;
    endcase
  endfunction

  function automatic item_t rnd_item(bit many_adds);
    item_t it;
    int pick;
    logic [63:0] l;
    pick = $urandom_range(0, 99);
    l = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) l = 64'd1 << $urandom_range(0, 63);
    it = mk(ACT_QUERY, rnd_coord(), rnd_coord(), 4'($urandom_range(0, 15)), l);
    if (pick < 3) it.act = ACT_CLEAR;
    else if (pick < 5) it.act = ACT_NONE;
    else if (pick < (many_adds ? 70 : 45)) it.act = ACT_ADD;
    if (it.act == ACT_QUERY && $urandom_range(0, 1)) it.kind = 4'($urandom_range(0, 3));
    return it;
  endfunction

  // write one register while idle; the caller drops cfg_valid after the last one
  task automatic write_reg(ase_reg_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_STEP_X: step_x = val[29:0];
      REG_STEP_Y: step_y = val[29:0];
      REG_OFF_X: off_x = longint'(signed'(val[30:0]));
      REG_OFF_Y: off_y = longint'(signed'(val[30:0]));
      REG_AUX_X: aux_x = longint'(signed'(val[30:0]));
      REG_AUX_Y: aux_y = longint'(signed'(val[30:0]));
      REG_MODE: mode = val[2:0];
      default: ;
    endcase
  endtask

  // offer one item after a random idle gap, predict on acceptance
  task automatic send_item(item_t it);
    snap_t r;
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action <= it.act;
    in_point_x <= COORD_W'(it.px);
    in_point_y <= COORD_W'(it.py);
    in_kind_flags <= it.kind;
    in_layer_mask <= it.layers;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = snap_item(it);
    if (it.fixed) r = '{it.ex, it.ey, it.ehit, it.eslot, it.estat};
    pending_snaps.insert(pending_snaps.size(), r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off when requested
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (out_ready && out_valid) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    snap_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_snaps.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        e = pending_snaps.pop_front();
        if (out_result_x !== COORD_W'(e.rx)) begin
          $error("result_x exp %0d got %0d", e.rx, out_result_x); errors++;
        end
        if (out_result_y !== COORD_W'(e.ry)) begin
          $error("result_y exp %0d got %0d", e.ry, out_result_y); errors++;
        end
        if (out_hit_anchor !== e.hit) begin
          $error("hit_anchor exp %0d got %0d", e.hit, out_hit_anchor); errors++;
        end
        if (out_anchor_slot !== SLOT_W'(e.slot)) begin
          $error("anchor_slot exp %0d got %0d", e.slot, out_anchor_slot); errors++;
        end
        if (out_status !== e.stat) begin
          $error("status exp %0d got %0d", e.stat, out_status); errors++;
        end
      end
    end
  end

  // bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("anchor_snap_engine verification failed");
      $finish;
    end
  end

  initial begin
    item_t it;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: fixed expectations where obvious, predictor elsewhere
    add_row(mk_fixed(mk(ACT_QUERY, 149999, -150000, 0, '1),
                     100000, -200000, 0, 0, 0));
    add_row(mk_fixed(mk(ACT_NONE, C_MAX, C_MIN, 4'hF, '1), 0, 0, 0, 0, 0));
    add_row(mk_fixed(mk(ACT_ADD, C_MAX, C_MIN, 4'hF, '1), 0, 0, 0, 0, 0));
    add_row(mk_fixed(mk(ACT_ADD, 10, 10, 4'h1, 64'h1), 0, 0, 0, 1, 0));
    add_row(mk(ACT_ADD, 10, 10, 4'h3, 64'h8000_0000_0000_0000));
    add_row(mk(ACT_QUERY, 12, 11, 4'h0, 64'h1));
    add_row(mk(ACT_QUERY, 12, 11, 4'h2, '1));
    add_row(mk(ACT_QUERY, 12, 11, 4'h0, 64'h2));
    add_row(mk(ACT_QUERY, C_MAX, C_MIN, 4'hF, '1));
    add_row(mk(ACT_QUERY, C_MIN, C_MAX, 4'h0, '0));
    add_row(mk(ACT_QUERY, 50000, -50000, 4'h0, '0));
    add_row(mk_fixed(mk(ACT_CLEAR, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    add_row(mk_fixed(mk(ACT_QUERY, 0, 0, 4'h0, '1), 0, 0, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);
    // fill the table to overflow it
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(mk(ACT_ADD, rnd_coord(), rnd_coord(), 4'hF, '1));
    send_item(mk(ACT_QUERY, 0, 0, 4'h0, '1));
    drain();

    // settings: extremes, aux axis, no grid, tiny and huge steps
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_STEP_X, 32'd1); write_reg(REG_STEP_Y, 32'd3);
          write_reg(REG_OFF_X, 32'h7FFF_FFFF); write_reg(REG_OFF_Y, 32'h4000_0000);
          write_reg(REG_AUX_X, 32'd7); write_reg(REG_AUX_Y, 32'h7FFF_FFF0);
          write_reg(REG_MODE, 32'd7);
        end
        1: begin
          write_reg(REG_STEP_X, 32'h3FFF_FFFF); write_reg(REG_STEP_Y, 32'h3FFF_FFFF);
          write_reg(REG_OFF_X, 32'h4000_0000); write_reg(REG_OFF_Y, 32'h3FFF_FFFF);
          write_reg(REG_MODE, 32'd5);
        end
        2: begin
          write_reg(REG_STEP_X, 32'd0); write_reg(REG_STEP_Y, 32'd0);
          write_reg(REG_MODE, 32'd2);
        end
        3: begin
          write_reg(REG_STEP_X, 32'd250000); write_reg(REG_STEP_Y, 32'd1000);
          write_reg(REG_OFF_X, 32'd123); write_reg(REG_OFF_Y, 32'hFFFF_FF00);
          write_reg(REG_AUX_X, 32'hFFFF_0000); write_reg(REG_AUX_Y, 32'd50);
          write_reg(REG_MODE, 32'd7);
        end
        4: write_reg(REG_MODE, 32'd0);
        default: begin
          write_reg(REG_STEP_X, 32'd100000); write_reg(REG_STEP_Y, 32'd100000);
          write_reg(REG_OFF_X, 32'd0); write_reg(REG_OFF_Y, 32'd0);
          write_reg(REG_MODE, 32'd3);
        end
      endcase
      cfg_valid <= 1'b0;
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        if (phase == 3 && n == 20) hold_off = 300;
        it = rnd_item(phase == 1);
        send_item(it);
      end
      drain();
    end
    if (errors == 0 && pending_snaps.size() == 0)
      $display("anchor_snap_engine verification clean");
    else
      $display("anchor_snap_engine verification failed");
    $finish;
  end

endmodule
